// File: rtl/core/dlii_pkg.sv
`default_nettype none
package dlii_pkg;

    localparam int COORD_W = 6;
    localparam int LEVEL_W = 17;
    // level quotient carries sign and one bit of headroom
    localparam int LQ_W    = LEVEL_W + 2;

    // divider retires this many quotient bits per cycle
    localparam int DIV_STEP = 2;
    localparam int DIV_ITER = (LEVEL_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_PAD  = DIV_ITER * DIV_STEP;
    localparam int DIV_CW   = $clog2(DIV_ITER);

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic [LEVEL_W-1:0] start_level;
        logic [LEVEL_W-1:0] end_level;
    } dlii_in_t;

    typedef struct packed {
        logic [COORD_W-1:0] point_x;
        logic [COORD_W-1:0] point_y;
        logic [LEVEL_W-1:0] point_level;
        logic               last_point;
    } dlii_out_t;

    typedef struct packed {
        logic load;
        logic setup;
        logic div_fin;
        logic step;
    } dlii_cmd_t;

    typedef struct packed {
        logic short_seg;
        logic div_done;
        logic out_free;
        logic last_pt;
    } dlii_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/dlii_divider.sv
`default_nettype none
module dlii_divider #(
    parameter int DEN_W = 6
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [dlii_pkg::LEVEL_W-1:0] dividend,
    input  wire logic [DEN_W-1:0]            divisor,
    output logic                             done,
    output logic [dlii_pkg::LEVEL_W-1:0]     quotient,
    output logic [DEN_W-1:0]                 remainder
);
    import dlii_pkg::*;

    logic [DIV_PAD-1:0] quo_reg;
    logic [DIV_PAD-1:0] quo_next;
    logic [DEN_W-1:0]   rem_reg;
    logic [DEN_W-1:0]   rem_next;
    logic [DEN_W-1:0]   den_reg;
    logic [DIV_CW-1:0]  cnt_reg;
    logic               busy_reg;
    logic [DEN_W:0]     trial;
    logic               last_iter;

    // restoring division, DIV_STEP bits per cycle
    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int j = 0; j < DIV_STEP; j++) begin
            trial    = {rem_next, quo_next[DIV_PAD-1]};
            quo_next = {quo_next[DIV_PAD-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                trial       = trial - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[DEN_W-1:0];
        end
    end

    assign last_iter = (cnt_reg == DIV_CW'(DIV_ITER - 1));
    assign done      = busy_reg && last_iter;
    assign quotient  = quo_reg[LEVEL_W-1:0];
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + DIV_CW'(1);
            if (last_iter) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= DIV_PAD'(dividend);
            rem_reg <= '0;
            den_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/dlii_datapath.sv
`default_nettype none
module dlii_datapath #(
    parameter int RASTER_SIDE = 64,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire dlii_pkg::dlii_in_t   s_data,
    input  wire dlii_pkg::dlii_cmd_t  cmd,
    output dlii_pkg::dlii_stat_t      stat,
    output dlii_pkg::dlii_out_t       m_data,
    output logic                      m_valid,
    input  wire logic                 m_ready
);
    import dlii_pkg::*;

    localparam int CW = $clog2(RASTER_SIDE);
    localparam logic [31:0] ONE_LEVEL = 32'd1 << FRAC_BITS;

    function automatic logic [CW-1:0] clip(input logic [COORD_W-1:0] v);
        logic [COORD_W:0] v_ext;
        v_ext = {1'b0, v};
        if (v_ext >= (COORD_W+1)'(RASTER_SIDE)) begin
            clip = CW'(RASTER_SIDE - 1);
        end else begin
            clip = v[CW-1:0];
        end
    endfunction

    // captured segment
    logic [CW-1:0]      x0_reg, y0_reg, x1_reg, y1_reg;
    logic [LEVEL_W-1:0] l0_reg, l1_reg;

    // setup terms
    logic signed [CW:0]  dx_c, dy_c;
    logic [CW-1:0]       adx_c, ady_c, steps_c;
    logic signed [LEVEL_W:0] diff_c;
    logic [LEVEL_W-1:0]  adiff_c;

    // walk state
    logic signed [CW:0]  dx_reg, dy_reg;
    logic [CW-1:0]       steps_reg, den_reg, k_reg;
    logic                flat_reg, neg_reg;
    logic [CW-1:0]       qx_reg, qy_reg;
    logic [CW:0]         rx_reg, ry_reg;
    logic signed [LQ_W-1:0] ql_reg, eq_reg;
    logic [CW:0]         rl_reg, er_reg;

    // divider
    logic [LEVEL_W-1:0]  div_quo;
    logic [CW-1:0]       div_rem;
    logic                div_done;

    // step terms
    logic signed [CW+2:0] two_steps, tx, ty;
    logic [CW-1:0]        qx_next, qy_next;
    logic [CW:0]          rx_next, ry_next;
    logic                 ymove;
    logic [CW+1:0]        tl, dd;
    logic                 lcarry;
    logic signed [LQ_W-1:0] ql_next, eq_pos;
    logic [CW:0]          rl_next;
    logic signed [31:0]   ql_ext;
    logic [31:0]          lvl32;
    logic                 last_c;

    dlii_out_t m_data_reg;
    logic      m_valid_reg;

    dlii_divider #(
        .DEN_W(CW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.setup),
        .dividend (adiff_c),
        .divisor  (ady_c),
        .done     (div_done),
        .quotient (div_quo),
        .remainder(div_rem)
    );

    always_comb begin
        dx_c    = $signed({1'b0, x1_reg}) - $signed({1'b0, x0_reg});
        dy_c    = $signed({1'b0, y1_reg}) - $signed({1'b0, y0_reg});
        adx_c   = CW'(dx_c[CW] ? -dx_c : dx_c);
        ady_c   = CW'(dy_c[CW] ? -dy_c : dy_c);
        steps_c = (adx_c > ady_c) ? adx_c : ady_c;
        diff_c  = $signed({1'b0, l1_reg}) - $signed({1'b0, l0_reg});
        adiff_c = LEVEL_W'(diff_c[LEVEL_W] ? -diff_c : diff_c);
        eq_pos  = $signed({2'b00, div_quo});
    end

    // exact dda: quotient and remainder of (2*d*k + steps) over 2*steps per axis
    always_comb begin
        two_steps = $signed({2'b00, steps_reg, 1'b0});
        tx = $signed({2'b00, rx_reg}) + $signed({dx_reg[CW], dx_reg, 1'b0});
        ty = $signed({2'b00, ry_reg}) + $signed({dy_reg[CW], dy_reg, 1'b0});

        qx_next = qx_reg;
        rx_next = tx[CW:0];
        if (!dx_reg[CW] && (tx >= two_steps)) begin
            qx_next = qx_reg + CW'(1);
            rx_next = (CW+1)'(tx - two_steps);
        end else if (dx_reg[CW] && (tx < 0)) begin
            qx_next = qx_reg - CW'(1);
            rx_next = (CW+1)'(tx + two_steps);
        end

        qy_next = qy_reg;
        ry_next = ty[CW:0];
        ymove   = 1'b0;
        if (!dy_reg[CW] && (ty >= two_steps)) begin
            qy_next = qy_reg + CW'(1);
            ry_next = (CW+1)'(ty - two_steps);
            ymove   = 1'b1;
        end else if (dy_reg[CW] && (ty < 0)) begin
            qy_next = qy_reg - CW'(1);
            ry_next = (CW+1)'(ty + two_steps);
            ymove   = 1'b1;
        end

        // level moves by (l1-l0)/den for each row step
        tl      = {1'b0, rl_reg} + {1'b0, er_reg};
        dd      = {1'b0, den_reg, 1'b0};
        lcarry  = (tl >= dd);
        ql_next = ql_reg;
        rl_next = rl_reg;
        if (ymove) begin
            ql_next = ql_reg + eq_reg + $signed({{(LQ_W-1){1'b0}}, lcarry});
            rl_next = lcarry ? (CW+1)'(tl - dd) : tl[CW:0];
        end

        ql_ext = 32'(ql_next);
        if (ql_ext < 0) begin
            lvl32 = '0;
        end else if ($unsigned(ql_ext) > ONE_LEVEL) begin
            lvl32 = ONE_LEVEL;
        end else begin
            lvl32 = $unsigned(ql_ext);
        end

        last_c = (k_reg == CW'(steps_reg - CW'(2)));
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x0_reg <= clip(s_data.start_x);
            y0_reg <= clip(s_data.start_y);
            x1_reg <= clip(s_data.end_x);
            y1_reg <= clip(s_data.end_y);
            l0_reg <= s_data.start_level;
            l1_reg <= s_data.end_level;
        end
        if (cmd.setup) begin
            dx_reg    <= dx_c;
            dy_reg    <= dy_c;
            steps_reg <= steps_c;
            den_reg   <= ady_c;
            flat_reg  <= (y0_reg == y1_reg);
            neg_reg   <= diff_c[LEVEL_W];
            qx_reg    <= x0_reg;
            rx_reg    <= {1'b0, steps_c};
            qy_reg    <= y0_reg;
            ry_reg    <= {1'b0, steps_c};
            ql_reg    <= $signed({2'b00, l0_reg});
            rl_reg    <= {1'b0, ady_c};
            k_reg     <= '0;
        end
        if (cmd.div_fin) begin
            if (!neg_reg) begin
                eq_reg <= eq_pos;
                er_reg <= {div_rem, 1'b0};
            end else if (div_rem == '0) begin
                eq_reg <= -eq_pos;
                er_reg <= '0;
            end else begin
                eq_reg <= -eq_pos - LQ_W'(1);
                er_reg <= {den_reg - div_rem, 1'b0};
            end
        end
        if (cmd.step) begin
            qx_reg <= qx_next;
            rx_reg <= rx_next;
            qy_reg <= qy_next;
            ry_reg <= ry_next;
            ql_reg <= ql_next;
            rl_reg <= rl_next;
            k_reg  <= k_reg + CW'(1);
            m_data_reg.point_x     <= COORD_W'(qx_next);
            m_data_reg.point_y     <= COORD_W'(qy_next);
            m_data_reg.point_level <= flat_reg ? ONE_LEVEL[LEVEL_W-1:0]
                                               : lvl32[LEVEL_W-1:0];
            m_data_reg.last_point  <= last_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;
    assign stat.short_seg = (steps_c < CW'(2));
    assign stat.div_done  = div_done;
    assign stat.out_free  = !m_valid_reg || m_ready;
    assign stat.last_pt   = last_c;

endmodule
`default_nettype wire

// File: rtl/core/dlii_ctrl.sv
`default_nettype none
module dlii_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire dlii_pkg::dlii_stat_t stat,
    output dlii_pkg::dlii_cmd_t       cmd
);
    import dlii_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_DFIN  = 3'd3;
    localparam logic [2:0] ST_WALK  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = stat.short_seg ? ST_IDLE : ST_DIV;
            end
            ST_DIV: begin
                if (stat.div_done) begin
                    state_next = ST_DFIN;
                end
            end
            ST_DFIN: begin
                cmd.div_fin = 1'b1;
                state_next  = ST_WALK;
            end
            ST_WALK: begin
                cmd.step = stat.out_free;
                if (stat.out_free && stat.last_pt) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/dda_line_intensity_interpolator_core.sv
// dda line walker with linear intensity along y
// input channel s_*: one segment per transaction (two endpoints, two levels)
// output channel m_*: one transaction per interior point, last_point marks
// the final point of a segment; segments shorter than two steps give none
// sequence: transaction accepted, a setup state, the level step divider
// (two quotient bits per cycle), a state to form the level increment,
// then one point per cycle while the receiver takes them; a new segment
// is accepted only once the walk of the last one is done
// a short segment returns to idle straight after setup
// the point walk is exact: per axis a quotient and remainder update on each
// step, the level follows the row with a precomputed step
// if the receiver stalls, the walk holds with the current point in the
// output register and resumes when it is taken
// reset (aresetn low, synchronous) returns to idle and drops m_valid
`default_nettype none
module dda_line_intensity_interpolator_core #(
    parameter int RASTER_SIDE = 64,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire dlii_pkg::dlii_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output dlii_pkg::dlii_out_t      m_data
);
    import dlii_pkg::*;

    dlii_cmd_t  cmd;
    dlii_stat_t stat;

    dlii_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    dlii_datapath #(
        .RASTER_SIDE(RASTER_SIDE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cmd    (cmd),
        .stat   (stat),
        .m_data (m_data),
        .m_valid(m_valid),
        .m_ready(m_ready)
    );

endmodule
`default_nettype wire

// File: sim/dlii_point_check.sv
module dlii_point_check #(
    parameter int RASTER_SIDE = 64,
    parameter int FRAC_BITS   = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  dlii_pkg::dlii_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  dlii_pkg::dlii_out_t m_data,
    output int                  fail_count,
    output int                  points_due,
    output int                  segments_seen,
    output int                  points_seen
);
    import dlii_pkg::*;

    localparam longint ONE_LEVEL  = longint'(1) << FRAC_BITS;
    localparam int     REPORT_MAX = 10;

    dlii_out_t interior_points[$];
    dlii_out_t want;

    function automatic longint clip_coord(logic [COORD_W-1:0] v);
        if (v >= RASTER_SIDE)
            return RASTER_SIDE - 1;
        return longint'(v);
    endfunction

    // exact position a + d*k/steps, half rounds up (never negative)
    function automatic longint walk_pos(longint a, longint d, longint k, longint steps);
        return (2 * (a * steps + d * k) + steps) / (2 * steps);
    endfunction

    function automatic void walk_segment(dlii_in_t seg);
        longint x0, y0, x1, y1, l0, l1, dx, dy, adx, ady, steps;
        longint px, py, den, num, lv;
        dlii_out_t pt;
        x0 = clip_coord(seg.start_x);
        y0 = clip_coord(seg.start_y);
        x1 = clip_coord(seg.end_x);
        y1 = clip_coord(seg.end_y);
        l0 = longint'(seg.start_level);
        l1 = longint'(seg.end_level);
        dx = x1 - x0;
        dy = y1 - y0;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        steps = (adx > ady) ? adx : ady;
        // endpoints are never emitted, so fewer than two steps gives nothing
        for (longint k = 1; k < steps; k++) begin
            px = walk_pos(x0, dx, k, steps);
            py = walk_pos(y0, dy, k, steps);
            if (y0 == y1) begin
                lv = ONE_LEVEL;
            end else begin
                den = y0 - y1;
                num = (py - y1) * l0 + (y0 - py) * l1;
                if (den < 0) begin
                    den = -den;
                    num = -num;
                end
                if (num >= 0)
                    lv = (2 * num + den) / (2 * den);
                else
                    lv = -((2 * (-num) + den) / (2 * den));
                if (lv > ONE_LEVEL)
                    lv = ONE_LEVEL;
                if (lv < 0)
                    lv = 0;
            end
            pt.point_x     = px[COORD_W-1:0];
            pt.point_y     = py[COORD_W-1:0];
            pt.point_level = lv[LEVEL_W-1:0];
            pt.last_point  = (k == steps - 1);
            interior_points = {interior_points, pt};
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            interior_points.delete();
            fail_count    = 0;
            segments_seen = 0;
            points_seen   = 0;
        end else begin
            if (s_valid && s_ready) begin
                walk_segment(s_data);
                segments_seen++;
            end
            if (m_valid && m_ready) begin
                points_seen++;
                if (interior_points.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: unexpected point x=%0d y=%0d level=%0d last=%0b",
                                 $time, m_data.point_x, m_data.point_y,
                                 m_data.point_level, m_data.last_point);
                end else begin
                    want = interior_points.pop_front();
                    if (m_data.point_x !== want.point_x ||
                        m_data.point_y !== want.point_y ||
                        m_data.point_level !== want.point_level ||
                        m_data.last_point !== want.last_point) begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display({"%0t: point differs, expected x=%0d y=%0d level=%0d ",
                                      "last=%0b, got x=%0d y=%0d level=%0d last=%0b"},
                                     $time, want.point_x, want.point_y,
                                     want.point_level, want.last_point,
                                     m_data.point_x, m_data.point_y,
                                     m_data.point_level, m_data.last_point);
                    end
                end
            end
        end
        // registered so the stimulus side never races the queue update
        points_due <= interior_points.size();
    end

endmodule

// File: sim/tb.sv
module tb;
    import dlii_pkg::*;

    localparam int LEVEL_ONE       = 1 << 16;
    localparam int RANDOM_SEGMENTS = 250;
    // quiet cycles tolerated: well above a segment's own setup and division time
    // and the runs of random stalls at 62%
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 80;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    dlii_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    dlii_out_t m_data;

    int fail_count, points_due, segments_seen, points_seen;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    dda_line_intensity_interpolator_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    dlii_point_check point_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .points_due    (points_due),
        .segments_seen (segments_seen),
        .points_seen   (points_seen)
    );

    always @(posedge aclk)
        m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic dlii_in_t make_segment(int sx, int sy, int ex, int ey, int sl, int el);
        dlii_in_t seg;
        seg.start_x     = COORD_W'(sx);
        seg.start_y     = COORD_W'(sy);
        seg.end_x       = COORD_W'(ex);
        seg.end_y       = COORD_W'(ey);
        seg.start_level = LEVEL_W'(sl);
        seg.end_level   = LEVEL_W'(el);
        return seg;
    endfunction

    function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] c, int span);
        int v;
        v = int'(c) + int'($urandom_range(2 * span, 0)) - span;
        if (v < 0)
            v = 0;
        if (v > (1 << COORD_W) - 1)
            v = (1 << COORD_W) - 1;
        return v[COORD_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] random_level();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return LEVEL_W'(LEVEL_ONE);
            2, 3:    return LEVEL_W'($urandom());  // may exceed one
            default: return LEVEL_W'($urandom_range(LEVEL_ONE, 0));
        endcase
    endfunction

    function automatic dlii_in_t random_segment();
        dlii_in_t seg;
        seg.start_x     = COORD_W'($urandom());
        seg.start_y     = COORD_W'($urandom());
        seg.end_x       = COORD_W'($urandom());
        seg.end_y       = COORD_W'($urandom());
        seg.start_level = random_level();
        seg.end_level   = random_level();
        case ($urandom_range(9, 0))
            0: begin
                // same or neighboring pixel, no points expected
                seg.end_x = near_coord(seg.start_x, 1);
                seg.end_y = near_coord(seg.start_y, 1);
            end
            1: seg.end_y = seg.start_y;
            2: begin
                // edge to edge span across all columns, the longest walks
                seg.start_x = $urandom_range(1, 0) ? '1 : '0;
                seg.end_x   = ~seg.start_x;
            end
            3, 4, 5: ;
            default: begin
                seg.end_x = near_coord(seg.start_x, 8);
                seg.end_y = near_coord(seg.start_y, 8);
            end
        endcase
        return seg;
    endfunction

    task automatic send_segment(input dlii_in_t seg);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= seg;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (points_due != 0);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_segment(make_segment(0, 0, 0, 0, 0, LEVEL_ONE));
        send_segment(make_segment(5, 5, 6, 6, LEVEL_ONE, 0));
        send_segment(make_segment(10, 10, 12, 11, 0, LEVEL_ONE));      // half rounds up
        send_segment(make_segment(63, 0, 61, 1, 40000, 20000));
        send_segment(make_segment(0, 20, 63, 20, 0, 0));               // flat row
        send_segment(make_segment(63, 45, 0, 45, 12345, 'h1FFFF));
        send_segment(make_segment(30, 0, 30, 63, 0, LEVEL_ONE));
        send_segment(make_segment(30, 63, 30, 0, LEVEL_ONE, 0));
        send_segment(make_segment(0, 0, 63, 63, 'h1FFFF, 'h1FFFF));    // clamps to one
        send_segment(make_segment(63, 0, 0, 63, 'h1FFFF, 0));
        send_segment(make_segment(63, 63, 0, 0, 12345, 54321));
        send_segment(make_segment(0, 10, 63, 13, 0, LEVEL_ONE));
        send_segment(make_segment(5, 0, 8, 63, LEVEL_ONE, 0));
        send_segment(make_segment(60, 40, 2, 37, 'hFFFF, 'h10000));
        send_segment(make_segment(0, 0, 40, 30, 0, 0));
        send_segment(make_segment(21, 42, 42, 21, 'h15555, 'h0AAAA));
        send_segment(make_segment(7, 9, 10, 13, 1, 65535));
        send_segment(make_segment(33, 33, 35, 33, 0, 0));
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            for (int n = 0; n < RANDOM_SEGMENTS / 4; n++)
                send_segment(random_segment());
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d segment transactions in, %0d point transactions checked", segments_seen,
                 points_seen);
        $display("directed edge cases, then random segments under four idle/stall mixes");
        if (fail_count == 0 && points_due == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
